@@ design/gregorian_day_of_year_convert_defines.svh @@
// ---------------------------------------------------------------------------
// gregorian_day_of_year_convert_defines.svh
// Assertion macros for the day-of-year converter.
// ---------------------------------------------------------------------------
`ifndef GREGORIAN_DAY_OF_YEAR_CONVERT_DEFINES_SVH
`define GREGORIAN_DAY_OF_YEAR_CONVERT_DEFINES_SVH

`ifndef SYNTHESIS
// clocked check, disabled while in reset
`define GDOY_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("gdoy assertion failed");
// clocked check, also active during reset
`define GDOY_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("gdoy assertion failed");
`else
`define GDOY_ASSERT(label, clk, rst_n, prop)
`define GDOY_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

@@ design/gdoy_pkg.sv @@
// ---------------------------------------------------------------------------
// gdoy_pkg
// Shared types, constants and the month length table.
// ---------------------------------------------------------------------------
`default_nettype none

package gdoy_pkg;

  localparam logic       CMD_TO_YEARDAY  = 1'b0;
  localparam logic       CMD_TO_MONTHDAY = 1'b1;

  localparam logic [3:0] MONTHS          = 4'd12;
  localparam logic [8:0] DAYS_YEAR       = 9'd365;
  localparam logic [8:0] DAYS_LEAP_YEAR  = 9'd366;

  // year / 25 by reciprocal: exact for all 14-bit years
  localparam int         YEAR_W          = 14;
  localparam int         RECIP_W         = 13;
  localparam int         PROD_W          = YEAR_W + RECIP_W;
  localparam int         RECIP_SHIFT     = 17;
  localparam int         QUOT_W          = PROD_W - RECIP_SHIFT;
  localparam logic [RECIP_W-1:0] RECIP25 = 13'd5243;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_QUOT,
    ST_LEAP,
    ST_WALK,
    ST_DONE
  } gdoy_state_t;

  typedef struct packed {
    logic load_in;
    logic calc_quot;
    logic calc_leap;
    logic walk_step;
    logic load_out;
  } gdoy_cmd_t;

  typedef struct packed {
    logic walk_done;
    logic out_busy;
  } gdoy_sts_t;

  function automatic logic [4:0] month_len(input logic leap, input logic [3:0] m);
    logic [4:0] len;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

@@ design/gregorian_day_of_year_convert.sv @@
// ---------------------------------------------------------------------------
// gregorian_day_of_year_convert
// Gregorian month/day <-> day-of-year converter with leap year handling.
// ---------------------------------------------------------------------------
// One item in, one result out. Command 0 turns month/day into day of year,
// command 1 turns day of year into month/day; impossible values set the
// error flag and zero the data. One item is worked at a time: three setup
// steps (capture, year/25 by reciprocal, leap and range check), then a walk
// over the months by the single month-length adder, then the output register
// is loaded. A new item is taken while the last result waits at the output.
`default_nettype none

`include "gregorian_day_of_year_convert_defines.svh"

module gregorian_day_of_year_convert (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // year[13:0], month_in[17:14], day_in[22:18],
                                       // yearday_in[31:23]
  input  wire logic [0:0]  in_tuser,   // cmd[0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // yearday_out[8:0], month_out[12:9],
                                       // day_out[17:13], zero[23:18]
  output logic [0:0]       out_tuser   // bad_value[0]
);

  gdoy_pkg::gdoy_cmd_t ctl_cmd;
  gdoy_pkg::gdoy_sts_t dp_sts;

  gdoy_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (dp_sts),
    .cmd       (ctl_cmd)
  );

  gdoy_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (ctl_cmd),
    .sts        (dp_sts),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  `GDOY_ASSERT(a_bad_zero_data, clk, rst_n, (out_tvalid && out_tuser[0]) |-> (out_tdata == 24'd0))
  `GDOY_ASSERT(a_accept_starts, clk, rst_n, (in_tvalid && in_tready) |=> ctl_cmd.calc_quot)
  `GDOY_ASSERT(a_no_overwrite, clk, rst_n, ctl_cmd.load_out |-> !dp_sts.out_busy)
  `GDOY_ASSERT(a_month_range, clk, rst_n,
    (out_tvalid && !out_tuser[0] && (out_tdata[12:9] != 4'd0)) |-> (out_tdata[12:9] <= 4'd12))

endmodule

`default_nettype wire

@@ design/gdoy_ctrl.sv @@
// ---------------------------------------------------------------------------
// gdoy_ctrl
// Sequencer: input accept, leap decision, month walk, result hand-off.
// ---------------------------------------------------------------------------
`default_nettype none

module gdoy_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire gdoy_pkg::gdoy_sts_t sts,
  output gdoy_pkg::gdoy_cmd_t    cmd
);

  gdoy_pkg::gdoy_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gdoy_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      gdoy_pkg::ST_IDLE: begin
        if (in_tvalid) state_nxt = gdoy_pkg::ST_QUOT;
      end
      gdoy_pkg::ST_QUOT: begin
        state_nxt = gdoy_pkg::ST_LEAP;
      end
      gdoy_pkg::ST_LEAP: begin
        state_nxt = gdoy_pkg::ST_WALK;
      end
      gdoy_pkg::ST_WALK: begin
        if (sts.walk_done) state_nxt = gdoy_pkg::ST_DONE;
      end
      gdoy_pkg::ST_DONE: begin
        if (!sts.out_busy) state_nxt = gdoy_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = gdoy_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_tready     = (state_r == gdoy_pkg::ST_IDLE);
    cmd.load_in   = (state_r == gdoy_pkg::ST_IDLE) && in_tvalid;
    cmd.calc_quot = (state_r == gdoy_pkg::ST_QUOT);
    cmd.calc_leap = (state_r == gdoy_pkg::ST_LEAP);
    cmd.walk_step = (state_r == gdoy_pkg::ST_WALK) && !sts.walk_done;
    cmd.load_out  = (state_r == gdoy_pkg::ST_DONE) && !sts.out_busy;
  end

endmodule

`default_nettype wire

@@ design/gdoy_dp.sv @@
// ---------------------------------------------------------------------------
// gdoy_dp
// Datapath: item registers, leap test, month walk adder, result register.
// ---------------------------------------------------------------------------
`default_nettype none

module gdoy_dp (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire gdoy_pkg::gdoy_cmd_t cmd,
  output gdoy_pkg::gdoy_sts_t      sts,
  input  wire logic [31:0]         in_tdata,
  input  wire logic [0:0]          in_tuser,
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  output logic [23:0]              out_tdata,
  output logic [0:0]               out_tuser
);

  logic                              op_r;
  logic [gdoy_pkg::YEAR_W-1:0]       year_r;
  logic [3:0]                        mon_r;
  logic [4:0]                        day_r;
  logic [8:0]                        yd_r;
  logic [gdoy_pkg::QUOT_W-1:0]       quot_r;
  logic                              leap_r;
  logic                              bad_r;
  logic [8:0]                        acc_r;
  logic [3:0]                        k_r;
  logic                              out_valid_r;
  logic [8:0]                        yd_out_r;
  logic [3:0]                        mon_out_r;
  logic [4:0]                        day_out_r;
  logic                              bad_out_r;

  logic [gdoy_pkg::PROD_W-1:0]       prod;
  logic [gdoy_pkg::YEAR_W-1:0]       mul25;
  logic [gdoy_pkg::YEAR_W-1:0]       rem25;
  logic                              leap_c;
  logic [4:0]                        len_mon;
  logic [8:0]                        limit;
  logic                              bad_c;
  logic [4:0]                        len_k;
  logic                              walk_done;

  assign prod  = gdoy_pkg::PROD_W'(year_r) * gdoy_pkg::PROD_W'(gdoy_pkg::RECIP25);
  assign mul25 = gdoy_pkg::YEAR_W'({quot_r, 4'b0000})
               + gdoy_pkg::YEAR_W'({quot_r, 3'b000})
               + gdoy_pkg::YEAR_W'(quot_r);
  assign rem25 = year_r - mul25;

  always_comb begin
    leap_c  = ((year_r[1:0] == 2'b00) && (rem25 != '0))
           || ((year_r[3:0] == 4'b0000) && (rem25 == '0));
    len_mon = gdoy_pkg::month_len(leap_c, mon_r);
    limit   = leap_c ? gdoy_pkg::DAYS_LEAP_YEAR : gdoy_pkg::DAYS_YEAR;
    if (op_r == gdoy_pkg::CMD_TO_MONTHDAY) begin
      bad_c = (yd_r == 9'd0) || (yd_r > limit);
    end else begin
      bad_c = (mon_r == 4'd0) || (mon_r > gdoy_pkg::MONTHS)
           || (day_r == 5'd0) || (day_r > len_mon);
    end
  end

  always_comb begin
    len_k = gdoy_pkg::month_len(leap_r, k_r);
    if (bad_r) begin
      walk_done = 1'b1;
    end else if (op_r == gdoy_pkg::CMD_TO_MONTHDAY) begin
      walk_done = !((k_r < gdoy_pkg::MONTHS) && (acc_r > 9'(len_k)));
    end else begin
      walk_done = (k_r >= mon_r);
    end
  end

  assign sts.walk_done = walk_done;
  assign sts.out_busy  = out_valid_r && !out_tready;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r   <= in_tuser[0];
      year_r <= in_tdata[13:0];
      mon_r  <= in_tdata[17:14];
      day_r  <= in_tdata[22:18];
      yd_r   <= in_tdata[31:23];
    end
    if (cmd.calc_quot) begin
      quot_r <= prod[gdoy_pkg::PROD_W-1:gdoy_pkg::RECIP_SHIFT];
    end
    if (cmd.calc_leap) begin
      leap_r <= leap_c;
      bad_r  <= bad_c;
      acc_r  <= (op_r == gdoy_pkg::CMD_TO_MONTHDAY) ? yd_r : 9'(day_r);
      k_r    <= 4'd1;
    end
    if (cmd.walk_step) begin
      if (op_r == gdoy_pkg::CMD_TO_MONTHDAY) begin
        acc_r <= acc_r - 9'(len_k);
      end else begin
        acc_r <= acc_r + 9'(len_k);
      end
      k_r <= k_r + 4'd1;
    end
    if (cmd.load_out) begin
      bad_out_r <= bad_r;
      if (bad_r) begin
        yd_out_r  <= 9'd0;
        mon_out_r <= 4'd0;
        day_out_r <= 5'd0;
      end else if (op_r == gdoy_pkg::CMD_TO_MONTHDAY) begin
        yd_out_r  <= 9'd0;
        mon_out_r <= k_r;
        day_out_r <= acc_r[4:0];
      end else begin
        yd_out_r  <= acc_r;
        mon_out_r <= 4'd0;
        day_out_r <= 5'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, day_out_r, mon_out_r, yd_out_r};
  assign out_tuser  = bad_out_r;

endmodule

`default_nettype wire

@@ dv/gregorian_day_of_year_convert_test.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gregorian_day_of_year_convert_test
// Self-checking bench for the month/day <-> day-of-year converter.
// ---------------------------------------------------------------------------
// A short table of directed items covers both commands, the field extremes,
// the leap rules and every rejection. About 1200 random items follow, mostly
// well-formed dates in years picked around the 4/100/400 rules, plus edge and
// noise items. Untyped items are predicted in-bench; all are queued. Each
// result is compared against the oldest queued expectation. The sender runs in
// bursts, and the receiver stalls on its own pattern. Once the receiver
// holds off long enough to back the block up.
// ---------------------------------------------------------------------------
module gregorian_day_of_year_convert_test;
  import gdoy_pkg::*;

  localparam int  ITEM_COUNT      = 1200;
  localparam int  HOLD_OFF_CYCLES = 400;
  localparam int  HOLD_OFF_AT     = 300;
  localparam int  STALL_LIMIT     = 2000;
  localparam int  DRAIN_CYCLES    = 40;
  localparam int  REPORT_LIMIT    = 10;
  localparam int  YEAR_MAX        = 16383;
  localparam logic BAD_DATE       = 1'b1;
  localparam logic GOOD_DATE      = 1'b0;
  localparam logic TYPED          = 1'b1;
  localparam logic PREDICTED      = 1'b0;

  typedef struct packed {
    logic        cmd;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [8:0]  yearday;
  } date_item_t;

  typedef struct packed {
    logic [8:0] yearday;
    logic [3:0] month;
    logic [4:0] day;
    logic       bad;
  } date_result_t;

  typedef struct packed {
    date_item_t   item;
    logic         typed;
    date_result_t want;
  } directed_row_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;   // year[13:0], month_in[17:14], day_in[22:18],
                                  // yearday_in[31:23]
  logic [0:0]  in_tuser   = '0;   // cmd[0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;         // yearday_out[8:0], month_out[12:9],
                                  // day_out[17:13], zero[23:18]
  logic [0:0]  out_tuser;         // bad_value[0]

  date_result_t pending_results [$];
  int           mismatches    = 0;
  int           results_seen  = 0;
  int           n_to_yearday  = 0;
  int           n_to_monthday = 0;
  int           n_rejected    = 0;
  int           n_leap        = 0;
  bit           held_off      = 1'b0;

  directed_row_t directed_rows [0:22] = '{
    '{'{CMD_TO_YEARDAY,  2023,  1,  1,   0}, TYPED,     '{  1,  0,  0, GOOD_DATE}},
    '{'{CMD_TO_YEARDAY,  2024, 12, 31,   0}, TYPED,     '{366,  0,  0, GOOD_DATE}},
    '{'{CMD_TO_YEARDAY,  2023, 12, 31,   0}, TYPED,     '{365,  0,  0, GOOD_DATE}},
    '{'{CMD_TO_YEARDAY,  2000,  2, 29,   0}, TYPED,     '{ 60,  0,  0, GOOD_DATE}},
    '{'{CMD_TO_YEARDAY,  1900,  2, 29,   0}, TYPED,     '{  0,  0,  0, BAD_DATE}},
    '{'{CMD_TO_YEARDAY,  2023,  0,  5,   0}, TYPED,     '{  0,  0,  0, BAD_DATE}},
    '{'{CMD_TO_YEARDAY,  2023, 13,  1,   0}, TYPED,     '{  0,  0,  0, BAD_DATE}},
    '{'{CMD_TO_YEARDAY,  2023, 15, 31, 511}, TYPED,     '{  0,  0,  0, BAD_DATE}},
    '{'{CMD_TO_YEARDAY,  2023,  4, 31,   0}, TYPED,     '{  0,  0,  0, BAD_DATE}},
    '{'{CMD_TO_YEARDAY,  2023,  6,  0,   0}, TYPED,     '{  0,  0,  0, BAD_DATE}},
    '{'{CMD_TO_YEARDAY,     0,  2, 29,   0}, TYPED,     '{ 60,  0,  0, GOOD_DATE}},
    '{'{CMD_TO_YEARDAY, 16383,  7, 15, 511}, PREDICTED, '{  0,  0,  0, GOOD_DATE}},
    '{'{CMD_TO_YEARDAY, 16000,  3,  1,   0}, PREDICTED, '{  0,  0,  0, GOOD_DATE}},
    '{'{CMD_TO_MONTHDAY, 2023,  0,  0,   1}, TYPED,     '{  0,  1,  1, GOOD_DATE}},
    '{'{CMD_TO_MONTHDAY, 2023,  0,  0, 365}, TYPED,     '{  0, 12, 31, GOOD_DATE}},
    '{'{CMD_TO_MONTHDAY, 2023,  0,  0, 366}, TYPED,     '{  0,  0,  0, BAD_DATE}},
    '{'{CMD_TO_MONTHDAY, 2024,  0,  0, 366}, TYPED,     '{  0, 12, 31, GOOD_DATE}},
    '{'{CMD_TO_MONTHDAY, 2024,  0,  0,   0}, TYPED,     '{  0,  0,  0, BAD_DATE}},
    '{'{CMD_TO_MONTHDAY, 2024, 15, 31, 511}, TYPED,     '{  0,  0,  0, BAD_DATE}},
    '{'{CMD_TO_MONTHDAY, 2024,  0,  0,  60}, TYPED,     '{  0,  2, 29, GOOD_DATE}},
    '{'{CMD_TO_MONTHDAY, 2100,  0,  0,  60}, PREDICTED, '{  0,  0,  0, GOOD_DATE}},
    '{'{CMD_TO_MONTHDAY,16383, 15, 31, 200}, PREDICTED, '{  0,  0,  0, GOOD_DATE}},
    '{'{CMD_TO_MONTHDAY, 9996,  0,  0, 366}, PREDICTED, '{  0,  0,  0, GOOD_DATE}}
  };

  gregorian_day_of_year_convert dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic is_leap_year(int y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int days_in_month(logic leap, int m);
    int lengths [13] = '{0, 31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    if (m < 1 || m > 12) begin
      return 0;
    end
    return (m == 2 && leap) ? 29 : lengths[m];
  endfunction

  function automatic date_result_t convert_date(date_item_t it);
    date_result_t r;
    logic         leap;
    int           rest;
    int           m;
    int           len;
    r    = '0;
    leap = is_leap_year(it.year);
    if (it.cmd == CMD_TO_YEARDAY) begin
      len = days_in_month(leap, it.month);
      if (len == 0 || it.day == 0 || it.day > len) begin
        r.bad = BAD_DATE;
      end else begin
        rest = it.day;
        for (m = 1; m < it.month; m++) rest += days_in_month(leap, m);
        r.yearday = 9'(rest);
      end
    end else begin
      if (it.yearday == 0 || it.yearday > (leap ? 366 : 365)) begin
        r.bad = BAD_DATE;
      end else begin
        rest = it.yearday;
        m    = 1;
        while (m < 12 && rest > days_in_month(leap, m)) begin
          rest -= days_in_month(leap, m);
          m++;
        end
        r.month = 4'(m);
        r.day   = 5'(rest);
      end
    end
    return r;
  endfunction

  // years biased toward the 4/100/400 boundaries; mostly valid dates
  function automatic date_item_t random_date();
    date_item_t it;
    int         pick;
    int         shape;
    int         len;
    int         limit;
    pick = $urandom_range(0, 9);
    if (pick == 3)      it.year = 14'($urandom_range(0, 40) * 400);
    else if (pick == 4) it.year = 14'($urandom_range(0, 163) * 100);
    else if (pick <= 6) it.year = 14'($urandom_range(0, 4095) * 4);
    else                it.year = 14'($urandom_range(0, YEAR_MAX));
    it.cmd     = 1'($urandom_range(0, 1));
    it.month   = 4'($urandom_range(0, 15));
    it.day     = 5'($urandom_range(0, 31));
    it.yearday = 9'($urandom_range(0, 511));
    shape = $urandom_range(0, 9);
    if (shape >= 2) begin
      if (it.cmd == CMD_TO_YEARDAY) begin
        it.month = 4'($urandom_range(1, 12));
        len      = days_in_month(is_leap_year(it.year), it.month);
        it.day   = 5'((shape == 2) ? len + $urandom_range(0, 1) : $urandom_range(1, len));
      end else begin
        limit      = is_leap_year(it.year) ? 366 : 365;
        it.yearday = 9'((shape == 2) ? limit + $urandom_range(0, 1)
                                     : $urandom_range(1, limit));
      end
    end
    return it;
  endfunction

  task automatic report_mismatch(string msg);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) begin
      $display("%0t mismatch: %s", $time, msg);
    end
  endtask

  int burst_left = 1;

  task automatic send_date(date_item_t it, date_result_t want);
    int gap;
    in_tdata  <= {it.yearday, it.day, it.month, it.year};
    in_tuser  <= it.cmd;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_results.push_back(want);
    if (it.cmd == CMD_TO_YEARDAY) n_to_yearday++;
    else                          n_to_monthday++;
    if (want.bad == BAD_DATE) n_rejected++;
    if (is_leap_year(it.year)) n_leap++;
    burst_left--;
    if (burst_left <= 0) begin
      gap = $urandom_range(1, 12);
      in_tvalid <= 1'b0;
      in_tdata  <= $urandom;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? 300 : $urandom_range(1, 40);
    end
  endtask

  // stimulus and end of run
  initial begin : stimulus
    date_item_t   it;
    date_result_t want;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed_rows[i]) begin
      it   = directed_rows[i].item;
      want = directed_rows[i].typed ? directed_rows[i].want : convert_date(it);
      send_date(it, want);
    end
    for (int i = 0; i < ITEM_COUNT; i++) begin
      it = random_date();
      send_date(it, convert_date(it));
    end
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    mismatches += pending_results.size();
    $display("covered %0d items: %0d to day of year, %0d to month/day, %0d rejected,",
             n_to_yearday + n_to_monthday, n_to_yearday, n_to_monthday, n_rejected);
    $display("%0d in leap years, %0d results checked, receiver hold-off done: %0d",
             n_leap, results_seen, held_off);
    if (mismatches == 0) begin
      $display("gregorian_day_of_year_convert_test: clean");
    end else begin
      $display("gregorian_day_of_year_convert_test: errors");
    end
    $finish;
  end

  // receiver: rotating stall patterns, one long hold-off
  initial begin : result_sink
    int  cyc;
    int  mode;
    logic rdy;
    cyc = 0;
    forever begin
      @(posedge clk);
      if (!held_off && results_seen >= HOLD_OFF_AT) begin
        out_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        held_off = 1'b1;
      end else begin
        cyc++;
        mode = (cyc / 64) % 4;
        case (mode)
          0:       rdy = 1'b1;
          1:       rdy = ($urandom_range(0, 9) > 2);
          2:       rdy = (cyc % 5 < 3);
          default: rdy = (cyc % 4 == 0);
        endcase
        out_tready <= rdy;
      end
    end
  end

  always @(posedge clk) begin
    date_result_t got;
    date_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      got = '{out_tdata[8:0], out_tdata[12:9], out_tdata[17:13], out_tuser[0]};
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected: yd=%0d m=%0d d=%0d bad=%0d",
                                  got.yearday, got.month, got.day, got.bad));
      end else begin
        want = pending_results.pop_front();
        if (got.yearday != want.yearday || got.month != want.month ||
            got.day != want.day || got.bad != want.bad || out_tdata[23:18] != '0) begin
          report_mismatch($sformatf(
            "expected yd=%0d m=%0d d=%0d bad=%0d, got yd=%0d m=%0d d=%0d bad=%0d pad=%0h",
            want.yearday, want.month, want.day, want.bad,
            got.yearday, got.month, got.day, got.bad, out_tdata[23:18]));
        end
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
    end
    $display("%0t timeout: no item moved for %0d cycles", $time, quiet);
    $display("gregorian_day_of_year_convert_test: errors");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+design
design/gdoy_pkg.sv
design/gdoy_ctrl.sv
design/gdoy_dp.sv
design/gregorian_day_of_year_convert.sv
dv/gregorian_day_of_year_convert_test.sv
